FILE: src/led_drv_pkg.sv
// Shared types and constants for the LED strip serial driver.
package led_drv_pkg;

  localparam int unsigned BITS_PER_LED = 24;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_SET      = 3'd1,
    OP_SET_SHOW = 3'd2,
    OP_SHOW     = 3'd3,
    OP_CLEAR    = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_RESET = 2'd1,
    PH_DATA  = 2'd2
  } phase_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_BUSY  = 2'd2;

  localparam logic [2:0] REG_LED_COUNT  = 3'd0;
  localparam logic [2:0] REG_ONE_HIGH   = 3'd1;
  localparam logic [2:0] REG_ZERO_HIGH  = 3'd2;
  localparam logic [2:0] REG_BIT_PERIOD = 3'd3;
  localparam logic [2:0] REG_RESET_LOW  = 3'd4;

endpackage

FILE: src/led_strip_serial_driver.sv
// Top level of the one-wire RGB LED strip driver with its pixel store.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid / in_stall  opcode, pixel_index, red/green/blue_level
//   out      output     out_valid/out_stall  line_level, busy_res, status
//   cfg      input      APB write/read       led_count, timing registers
//
// Each transaction's result is registered; a new one is taken every cycle unless
// in_stall is high. The result register frees on the same edge it is taken, so no
// bubble appears. After reset the pixel store is zeroed by a pass over all MAX_LEDS
// addresses, during which in_stall is high. Each LED's color is prefetched from the
// store during the previous LED, so the single read port never delays a tick.
module led_strip_serial_driver #(
  parameter int unsigned MAX_LEDS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  opcode,
  input  logic [15:0] pixel_index,
  input  logic [7:0]  red_level,
  input  logic [7:0]  green_level,
  input  logic [7:0]  blue_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        line_level,
  output logic        busy_res,
  output logic [1:0]  status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import led_drv_pkg::*;

  localparam int unsigned AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int unsigned LW = $clog2(MAX_LEDS + 1);
  localparam logic [15:0] MAX_LEDS_W = 16'(MAX_LEDS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_LEDS - 1);

  logic [8:0]  led_count;
  logic [7:0]  one_high_ticks;
  logic [7:0]  zero_high_ticks;
  logic [7:0]  bit_period_ticks;
  logic [15:0] reset_low_ticks;

  phase_t      phase, phase_next;
  logic [LW-1:0] led_pos, led_pos_next;
  logic [4:0]  bit_pos, bit_pos_next;
  logic [15:0] tick_count, tick_count_next;
  logic        clearing, clearing_next;
  logic [23:0] shift_word, shift_word_next;
  logic        line_out, line_out_next;

  logic        init;
  logic [AW-1:0] init_cnt;

  logic [23:0] store [MAX_LEDS];
  logic [23:0] rd_data;
  logic        byp;
  logic [23:0] byp_data;
  logic [23:0] fetch_word;

  logic        st_we;
  logic [AW-1:0] st_waddr;
  logic [23:0] st_wdata;
  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  logic [23:0] mem_wdata;
  logic [AW-1:0] mem_raddr;

  logic        in_accept;
  logic        cfg_write;
  logic [1:0]  status_next;
  logic [15:0] active_cnt;
  logic [15:0] reset_len;
  logic [7:0]  period;
  logic [7:0]  high_ticks;
  logic [15:0] tick_inc;
  logic [LW-1:0] led_inc;
  logic [15:0] led_inc_w;
  logic        busy;
  logic        idx_ok;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign in_stall  = init || (out_valid && out_stall);
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      led_count        <= 9'd0;
      one_high_ticks   <= 8'd13;
      zero_high_ticks  <= 8'd6;
      bit_period_ticks <= 8'd20;
      reset_low_ticks  <= 16'd880;
    end else if (cfg_write) begin
      case (paddr[4:2])
        REG_LED_COUNT:  led_count        <= pwdata[8:0];
        REG_ONE_HIGH:   one_high_ticks   <= pwdata[7:0];
        REG_ZERO_HIGH:  zero_high_ticks  <= pwdata[7:0];
        REG_BIT_PERIOD: bit_period_ticks <= pwdata[7:0];
        REG_RESET_LOW:  reset_low_ticks  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_LED_COUNT:  prdata = {23'd0, led_count};
      REG_ONE_HIGH:   prdata = {24'd0, one_high_ticks};
      REG_ZERO_HIGH:  prdata = {24'd0, zero_high_ticks};
      REG_BIT_PERIOD: prdata = {24'd0, bit_period_ticks};
      REG_RESET_LOW:  prdata = {16'd0, reset_low_ticks};
      default:        prdata = 32'd0;
    endcase
  end

  assign active_cnt = ({7'd0, led_count} > MAX_LEDS_W) ? MAX_LEDS_W : {7'd0, led_count};
  assign reset_len  = (reset_low_ticks == 16'd0) ? 16'd1 : reset_low_ticks;
  assign period     = (bit_period_ticks == 8'd0) ? 8'd1 : bit_period_ticks;
  assign high_ticks = shift_word[23] ? one_high_ticks : zero_high_ticks;
  assign tick_inc   = tick_count + 16'd1;
  assign led_inc    = led_pos + LW'(1);
  assign led_inc_w  = 16'(led_inc);
  assign busy       = (phase != PH_IDLE);
  assign idx_ok     = (pixel_index < active_cnt);
  assign fetch_word = byp ? byp_data : rd_data;

  // The store is read one LED ahead while data is on the line.
  assign mem_raddr = (phase == PH_DATA) ? led_inc[AW-1:0] : '0;

  always_comb begin
    phase_next      = phase;
    led_pos_next    = led_pos;
    bit_pos_next    = bit_pos;
    tick_count_next = tick_count;
    clearing_next   = clearing;
    shift_word_next = shift_word;
    line_out_next   = line_out;
    if (in_accept) begin
      case (opcode)
        OP_TICK: begin
          case (phase)
            PH_RESET: begin
              line_out_next = 1'b0;
              if (tick_inc >= reset_len) begin
                tick_count_next = 16'd0;
                led_pos_next    = '0;
                bit_pos_next    = 5'd0;
                if (active_cnt == 16'd0) begin
                  phase_next    = PH_IDLE;
                  clearing_next = 1'b0;
                end else begin
                  phase_next      = PH_DATA;
                  shift_word_next = clearing ? 24'd0 : fetch_word;
                end
              end else begin
                tick_count_next = tick_inc;
              end
            end
            PH_DATA: begin
              line_out_next = (tick_count < {8'd0, high_ticks});
              if (tick_inc >= {8'd0, period}) begin
                tick_count_next = 16'd0;
                shift_word_next = {shift_word[22:0], 1'b0};
                if (bit_pos == 5'(BITS_PER_LED - 1)) begin
                  bit_pos_next = 5'd0;
                  if (led_inc_w >= active_cnt) begin
                    phase_next    = PH_IDLE;
                    clearing_next = 1'b0;
                    led_pos_next  = '0;
                    line_out_next = 1'b0;
                  end else begin
                    led_pos_next    = led_inc;
                    shift_word_next = clearing ? 24'd0 : fetch_word;
                  end
                end else begin
                  bit_pos_next = bit_pos + 5'd1;
                end
              end else begin
                tick_count_next = tick_inc;
              end
            end
            default: line_out_next = 1'b0;
          endcase
        end
        OP_SET_SHOW, OP_SHOW, OP_CLEAR: begin
          if (!busy && (opcode != OP_SET_SHOW || idx_ok)) begin
            phase_next      = PH_RESET;
            tick_count_next = 16'd0;
            led_pos_next    = '0;
            bit_pos_next    = 5'd0;
            clearing_next   = (opcode == OP_CLEAR);
            line_out_next   = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    status_next = ST_OK;
    st_we       = 1'b0;
    st_waddr    = pixel_index[AW-1:0];
    st_wdata    = {green_level, red_level, blue_level};
    if (in_accept) begin
      case (opcode)
        OP_TICK: begin
          if (clearing && phase == PH_DATA && phase_next == PH_DATA &&
              led_pos_next != led_pos) begin
            st_we    = 1'b1;
            st_waddr = led_inc[AW-1:0];
            st_wdata = 24'd0;
          end else if (clearing && phase == PH_RESET && phase_next == PH_DATA) begin
            st_we    = 1'b1;
            st_waddr = '0;
            st_wdata = 24'd0;
          end
        end
        OP_SET, OP_SET_SHOW: begin
          if (busy) begin
            status_next = ST_BUSY;
          end else if (idx_ok) begin
            st_we = 1'b1;
          end else begin
            status_next = ST_RANGE;
          end
        end
        OP_SHOW, OP_CLEAR: begin
          if (busy) begin
            status_next = ST_BUSY;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      led_pos    <= '0;
      bit_pos    <= 5'd0;
      tick_count <= 16'd0;
      clearing   <= 1'b0;
      shift_word <= 24'd0;
      line_out   <= 1'b0;
    end else begin
      phase      <= phase_next;
      led_pos    <= led_pos_next;
      bit_pos    <= bit_pos_next;
      tick_count <= tick_count_next;
      clearing   <= clearing_next;
      shift_word <= shift_word_next;
      line_out   <= line_out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init     <= 1'b1;
      init_cnt <= '0;
    end else if (init) begin
      if (init_cnt == LAST_ADDR) begin
        init <= 1'b0;
      end else begin
        init_cnt <= init_cnt + AW'(1);
      end
    end
  end

  assign mem_we    = init || st_we;
  assign mem_waddr = init ? init_cnt : st_waddr;
  assign mem_wdata = init ? 24'd0 : st_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    rd_data  <= store[mem_raddr];
    byp      <= mem_we && (mem_waddr == mem_raddr);
    byp_data <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      line_level <= line_out_next;
      busy_res   <= (phase_next != PH_IDLE);
      status     <= status_next;
    end
  end

`ifndef SYNTHESIS
  a_idle_line_low: assert property (@(posedge clk) disable iff (rst)
    out_valid && !busy_res |-> !line_level)
    else $error("Line is high in a result that reports an idle strip.");

  a_busy_reject: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && phase != PH_IDLE &&
    (opcode == OP_SET || opcode == OP_SET_SHOW || opcode == OP_SHOW || opcode == OP_CLEAR)
    |=> out_valid && status == ST_BUSY && busy_res)
    else $error("Command during a frame was not rejected.");

  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    bit_pos < 5'(BITS_PER_LED))
    else $error("Bit position ran past the end of an LED word.");

  a_led_range: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> {{(16 - LW){1'b0}}, led_pos} < active_cnt)
    else $error("LED position is outside the strip while sending data.");

  a_init_stall: assert property (@(posedge clk) disable iff (rst)
    init |-> in_stall && phase == PH_IDLE)
    else $error("Transaction accepted while the pixel store is being cleared.");
`endif

endmodule
